// File: rtl/core/srwm_pkg.sv
`default_nettype none

package srwm_pkg;

    localparam int CODE_W     = 12;
    localparam int MV_W       = 14;
    localparam int CENTI_W    = 19;
    localparam int RCOUNT_W   = 16;
    localparam int VTOT_W     = 30;
    localparam int TTOT_W     = 36;
    localparam int YC_W       = 34;
    localparam int DIV_W      = 35;
    localparam int DIV_CNT_W  = 6;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 152;

    // mv = code * 9900 >> 12
    localparam logic [MV_W-1:0] MV_SCALE = 14'd9900;
    localparam int              MV_SHIFT = 12;

    // centi = 43724 - floor((code * 2578125 + 73728) / 55072)
    // 55072 = 32 * 1721, the divide by 1721 is a reciprocal multiply, exact below 2^29
    localparam logic [21:0]        CENTI_MUL         = 22'd2578125;
    localparam logic [16:0]        CENTI_OFS         = 17'd73728;
    localparam int                 CENTI_PRE_SHIFT   = 5;
    localparam int                 YS_W              = YC_W - CENTI_PRE_SHIFT;
    localparam int                 CENTI_RECIP_W     = 30;
    localparam logic [29:0]        CENTI_RECIP       = 30'd638879505;
    localparam int                 CENTI_RECIP_SHIFT = 40;
    localparam int                 RECIP_W           = YS_W + CENTI_RECIP_W;
    localparam logic signed [19:0] CENTI_BASE        = 20'sd43724;

    localparam logic signed [TTOT_W:0] TTOT_POS = 37'sh7_FFFF_FFFF;
    localparam logic signed [TTOT_W:0] TTOT_NEG = -37'sh7_FFFF_FFFF;

    typedef enum logic {
        DIV_VMEAN,
        DIV_TMEAN
    } srwm_div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_RECIP,
        ST_CENTI,
        ST_STATS,
        ST_DIV_V,
        ST_WAIT_V,
        ST_DIV_T,
        ST_WAIT_T,
        ST_OUT
    } srwm_state_t;

    typedef struct packed {
        logic          accept;
        logic          mul_en;
        logic          recip_en;
        logic          div_start;
        srwm_div_sel_t div_sel;
        logic          centi_load;
        logic          stats_update;
        logic          vmean_load;
        logic          tmean_load;
        logic          out_load;
    } srwm_cmd_t;

    typedef struct packed {
        logic last_conv;
        logic div_done;
        logic out_full;
    } srwm_status_t;

endpackage

`default_nettype wire

// File: rtl/core/srwm_div.sv
`default_nettype none

module srwm_div #(
    parameter int DVS_W = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [srwm_pkg::DIV_W-1:0] dividend,
    input  wire logic [DVS_W-1:0]         divisor,
    output logic                          done,
    output logic [srwm_pkg::DIV_W-1:0]    quotient
);

    import srwm_pkg::*;

    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DVS_W:0]       trial;
    logic [DVS_W:0]       diff;
    logic                 fits;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;

        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = DIV_CNT_W'(DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            quo_next  = {quo_reg[DIV_W-2:0], fits};
            rem_next  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/core/srwm_datapath.sv
`default_nettype none

module srwm_datapath #(
    parameter int SAMPLES_LOG2 = 6,
    parameter int COUNT_BITS   = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire srwm_pkg::srwm_cmd_t                cmd,
    output srwm_pkg::srwm_status_t                  status,
    input  wire logic [srwm_pkg::CODE_W-1:0]        vsys_code,
    input  wire logic [srwm_pkg::CODE_W-1:0]        temp_code,
    input  wire logic                               vbus_level,
    input  wire logic                               window_end,
    input  wire logic                               cfg_wr_en,
    input  wire logic                               cfg_wr_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [srwm_pkg::OUT_DATA_W-1:0]         out_data,
    output logic                                    out_last
);

    import srwm_pkg::*;

    localparam int IDX_W = (SAMPLES_LOG2 > 0) ? SAMPLES_LOG2 : 1;
    localparam int ACC_W = CODE_W + SAMPLES_LOG2;
    localparam int DVS_W = COUNT_BITS;
    localparam logic [IDX_W-1:0]      IDX_LAST  = IDX_W'((1 << SAMPLES_LOG2) - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                        sense_reg, sense_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [ACC_W-1:0]            vacc_reg, vacc_next;
    logic [ACC_W-1:0]            tacc_reg, tacc_next;
    logic [CODE_W-1:0]           vavg_reg, vavg_next;
    logic [CODE_W-1:0]           tavg_reg, tavg_next;
    logic                        vbus_now_reg, vbus_now_next;
    logic                        wend_reg, wend_next;
    logic [MV_W-1:0]             mv_reg, mv_next;
    logic [YS_W-1:0]             yc_reg, yc_next;
    logic [CENTI_W-1:0]          cq_reg, cq_next;
    logic signed [CENTI_W-1:0]   centi_reg, centi_next;
    logic [MV_W-1:0]             vmin_reg, vmin_next;
    logic [MV_W-1:0]             vmax_reg, vmax_next;
    logic signed [CENTI_W-1:0]   tmin_reg, tmin_next;
    logic signed [CENTI_W-1:0]   tmax_reg, tmax_next;
    logic [VTOT_W-1:0]           vtot_reg, vtot_next;
    logic signed [TTOT_W-1:0]    ttot_reg, ttot_next;
    logic [COUNT_BITS-1:0]       cnt_reg, cnt_next;
    logic                        absent_reg, absent_next;
    logic [MV_W-1:0]             vmean_reg, vmean_next;
    logic signed [CENTI_W-1:0]   tmean_reg, tmean_next;
    logic                        out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]       out_data_reg, out_data_next;
    logic                        out_last_reg, out_last_next;

    logic [ACC_W-1:0]            vsum;
    logic [ACC_W-1:0]            tsum_acc;
    logic [25:0]                 mv_prod;
    logic [YC_W-1:0]             yc_prod;
    logic [RECIP_W-1:0]          recip_prod;
    logic signed [19:0]          centi_diff;
    logic [VTOT_W:0]             vtot_sum;
    logic signed [TTOT_W:0]      ttot_sum;
    logic signed [TTOT_W:0]      centi_ext;
    logic [TTOT_W-1:0]           tmag;
    logic [CENTI_W-1:0]          tq;
    logic [RCOUNT_W+COUNT_BITS-1:0] cnt_wide;
    logic [DIV_W-1:0]            div_dividend;
    logic [DVS_W-1:0]            div_divisor;
    logic                        div_done;
    logic [DIV_W-1:0]            div_quo;

    srwm_div #(
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        tmag = ttot_reg[TTOT_W-1] ? TTOT_W'(-ttot_reg) : TTOT_W'(ttot_reg);
        div_divisor = DVS_W'(cnt_reg);
        case (cmd.div_sel)
            DIV_TMEAN: div_dividend = tmag[DIV_W-1:0];
            default:   div_dividend = DIV_W'(vtot_reg);
        endcase
    end

    always_comb
    begin
        vsum       = vacc_reg + ACC_W'(vsys_code);
        tsum_acc   = tacc_reg + ACC_W'(temp_code);
        mv_prod    = 26'(vavg_reg) * 26'(MV_SCALE);
        yc_prod    = YC_W'(tavg_reg) * YC_W'(CENTI_MUL) + YC_W'(CENTI_OFS);
        recip_prod = RECIP_W'(yc_reg) * RECIP_W'(CENTI_RECIP);
        centi_diff = CENTI_BASE - $signed({1'b0, cq_reg});
        vtot_sum   = {1'b0, vtot_reg} + (VTOT_W+1)'(mv_reg);
        centi_ext  = $signed({{(TTOT_W+1-CENTI_W){centi_reg[CENTI_W-1]}}, centi_reg});
        ttot_sum   = $signed({ttot_reg[TTOT_W-1], ttot_reg}) + centi_ext;
        tq         = div_quo[CENTI_W-1:0];
        cnt_wide   = {{RCOUNT_W{1'b0}}, cnt_reg};

        sense_next     = cfg_wr_en ? cfg_wr_data : sense_reg;
        idx_next       = idx_reg;
        vacc_next      = vacc_reg;
        tacc_next      = tacc_reg;
        vavg_next      = vavg_reg;
        tavg_next      = tavg_reg;
        vbus_now_next  = vbus_now_reg;
        wend_next      = wend_reg;
        mv_next        = mv_reg;
        yc_next        = yc_reg;
        cq_next        = cq_reg;
        centi_next     = centi_reg;
        vmin_next      = vmin_reg;
        vmax_next      = vmax_reg;
        tmin_next      = tmin_reg;
        tmax_next      = tmax_reg;
        vtot_next      = vtot_reg;
        ttot_next      = ttot_reg;
        cnt_next       = cnt_reg;
        absent_next    = absent_reg;
        vmean_next     = vmean_reg;
        tmean_next     = tmean_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (cmd.accept)
        begin
            if (idx_reg == IDX_LAST)
            begin
                idx_next      = '0;
                vacc_next     = '0;
                tacc_next     = '0;
                vavg_next     = vsum[ACC_W-1:SAMPLES_LOG2];
                tavg_next     = tsum_acc[ACC_W-1:SAMPLES_LOG2];
                vbus_now_next = vbus_level && sense_reg;
                wend_next     = window_end;
            end
            else
            begin
                idx_next  = idx_reg + 1'b1;
                vacc_next = vsum;
                tacc_next = tsum_acc;
            end
        end

        if (cmd.mul_en)
        begin
            mv_next = mv_prod[MV_SHIFT+MV_W-1:MV_SHIFT];
            yc_next = yc_prod[YC_W-1:CENTI_PRE_SHIFT];
        end

        if (cmd.recip_en)
            cq_next = recip_prod[RECIP_W-1:CENTI_RECIP_SHIFT];

        if (cmd.centi_load)
            centi_next = centi_diff[CENTI_W-1:0];

        if (cmd.stats_update)
        begin
            if (cnt_reg == '0)
            begin
                vmin_next   = mv_reg;
                vmax_next   = mv_reg;
                tmin_next   = centi_reg;
                tmax_next   = centi_reg;
                vtot_next   = VTOT_W'(mv_reg);
                ttot_next   = centi_ext[TTOT_W-1:0];
                cnt_next    = COUNT_BITS'(1);
                absent_next = !vbus_now_reg;
            end
            else
            begin
                if (mv_reg < vmin_reg)
                    vmin_next = mv_reg;
                if (mv_reg > vmax_reg)
                    vmax_next = mv_reg;
                if (centi_reg < tmin_reg)
                    tmin_next = centi_reg;
                if (centi_reg > tmax_reg)
                    tmax_next = centi_reg;
                if (cnt_reg != COUNT_MAX)
                begin
                    vtot_next = vtot_sum[VTOT_W] ? {VTOT_W{1'b1}} : vtot_sum[VTOT_W-1:0];
                    if (ttot_sum > TTOT_POS)
                        ttot_next = TTOT_POS[TTOT_W-1:0];
                    else if (ttot_sum < TTOT_NEG)
                        ttot_next = TTOT_NEG[TTOT_W-1:0];
                    else
                        ttot_next = ttot_sum[TTOT_W-1:0];
                    cnt_next = cnt_reg + 1'b1;
                end
                if (!vbus_now_reg)
                    absent_next = 1'b1;
            end
        end

        if (cmd.vmean_load)
            vmean_next = div_quo[MV_W-1:0];

        if (cmd.tmean_load)
            tmean_next = ttot_reg[TTOT_W-1] ? (CENTI_W'(0) - tq) : tq;

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_last_next  = wend_reg;
            out_data_next  = {2'b00, absent_reg, cnt_wide[RCOUNT_W-1:0],
                              tmean_reg, tmax_reg, tmin_reg,
                              vmean_reg, vmax_reg, vmin_reg,
                              vbus_now_reg, centi_reg, mv_reg};
            if (wend_reg)
            begin
                vmin_next   = '0;
                vmax_next   = '0;
                tmin_next   = '0;
                tmax_next   = '0;
                vtot_next   = '0;
                ttot_next   = '0;
                cnt_next    = '0;
                absent_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sense_reg     <= 1'b1;
            idx_reg       <= '0;
            vacc_reg      <= '0;
            tacc_reg      <= '0;
            vmin_reg      <= '0;
            vmax_reg      <= '0;
            tmin_reg      <= '0;
            tmax_reg      <= '0;
            vtot_reg      <= '0;
            ttot_reg      <= '0;
            cnt_reg       <= '0;
            absent_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sense_reg     <= sense_next;
            idx_reg       <= idx_next;
            vacc_reg      <= vacc_next;
            tacc_reg      <= tacc_next;
            vmin_reg      <= vmin_next;
            vmax_reg      <= vmax_next;
            tmin_reg      <= tmin_next;
            tmax_reg      <= tmax_next;
            vtot_reg      <= vtot_next;
            ttot_reg      <= ttot_next;
            cnt_reg       <= cnt_next;
            absent_reg    <= absent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vavg_reg     <= vavg_next;
        tavg_reg     <= tavg_next;
        vbus_now_reg <= vbus_now_next;
        wend_reg     <= wend_next;
        mv_reg       <= mv_next;
        yc_reg       <= yc_next;
        cq_reg       <= cq_next;
        centi_reg    <= centi_next;
        vmean_reg    <= vmean_next;
        tmean_reg    <= tmean_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign status.last_conv = (idx_reg == IDX_LAST);
    assign status.div_done  = div_done;
    assign status.out_full  = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/srwm_ctrl.sv
`default_nettype none

module srwm_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire srwm_pkg::srwm_status_t status,
    output srwm_pkg::srwm_cmd_t         cmd
);

    import srwm_pkg::*;

    srwm_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.last_conv)
                    state_next = ST_MUL;
            end
            ST_MUL:    state_next = ST_RECIP;
            ST_RECIP:  state_next = ST_CENTI;
            ST_CENTI:  state_next = ST_STATS;
            ST_STATS:  state_next = ST_DIV_V;
            ST_DIV_V:  state_next = ST_WAIT_V;
            ST_WAIT_V:
            begin
                if (status.div_done)
                    state_next = ST_DIV_T;
            end
            ST_DIV_T:  state_next = ST_WAIT_T;
            ST_WAIT_T:
            begin
                if (status.div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!status.out_full)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        cmd.div_sel = DIV_VMEAN;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_MUL:    cmd.mul_en = 1'b1;
            ST_RECIP:  cmd.recip_en = 1'b1;
            ST_CENTI:  cmd.centi_load = 1'b1;
            ST_STATS:  cmd.stats_update = 1'b1;
            ST_DIV_V:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_VMEAN;
            end
            ST_WAIT_V:
            begin
                cmd.div_sel    = DIV_VMEAN;
                cmd.vmean_load = status.div_done;
            end
            ST_DIV_T:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_TMEAN;
            end
            ST_WAIT_T:
            begin
                cmd.div_sel    = DIV_TMEAN;
                cmd.tmean_load = status.div_done;
            end
            ST_OUT:    cmd.out_load = !status.out_full;
            default:   cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/supply_rail_window_monitor.sv
`default_nettype none

// channel     | dir | transaction
// s_axis      | in  | one conversion pair, tlast closes the window
// m_axis      | out | one reading with window statistics, tlast on window close
// cfg_wr      | in  | vbus sense present bit
//
// a transaction that is not the last of a reading is accepted without stalling s_axis
// the last one of a reading holds s_axis_tready low through scaling,
// the centidegree reciprocal multiply and the statistics, then two 35-step mean
// divisions on one shared divider, then the load of m_axis
// the load waits while the previous m_axis transaction is held, adding its stall
// m_axis is a holding register, so conversions of the next reading flow while it waits
// rst_n clears the accumulators, the window statistics and sets vbus sense present

module supply_rail_window_monitor #(
    parameter int SAMPLES_LOG2 = 6,
    parameter int COUNT_BITS   = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // vsys_code, temp_code, vbus_level
    input  wire logic [srwm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  wire logic                              s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // vsys_mv, temp_centi, vbus_now, vsys_min_mv, vsys_max_mv, vsys_mean_mv,
    // temp_min_centi, temp_max_centi, temp_mean_centi, reading_count, vbus_dropped
    output logic [srwm_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    output logic                                   m_axis_tlast,
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_wr_data
);

    import srwm_pkg::*;

    srwm_cmd_t    cmd;
    srwm_status_t status;

    srwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    srwm_datapath #(
        .SAMPLES_LOG2 (SAMPLES_LOG2),
        .COUNT_BITS   (COUNT_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .vsys_code   (s_axis_tdata[CODE_W-1:0]),
        .temp_code   (s_axis_tdata[2*CODE_W-1:CODE_W]),
        .vbus_level  (s_axis_tdata[2*CODE_W]),
        .window_end  (s_axis_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_last    (m_axis_tlast)
    );

endmodule

`default_nettype wire
